// ----- src/tepq_pkg.sv -----
// Shared types and codes for the timer expiry queue.
package tepq_pkg;

   localparam int TIME_W = 48;
   localparam int ID_W   = 32;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_STOP  = 2'd1,
      OP_POLL  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_NO_EXPIRY = 2'd3
   } status_type;

   // Controller commands to the datapath.
   typedef struct packed {
      logic load;       // capture the item's fields
      logic scan_clr;   // reset scan pointers and flags
      logic rd;         // read slot at rd_ptr
      logic eval;       // examine read data
      logic wr_start;   // append new timer
      logic shift;      // copy read entry to wr_ptr
      logic finish;     // update count and next id, emit result
   } dp_cmd_type;

   // Datapath status back to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic rd_last;    // rd_ptr is the last valid slot
   } dp_sts_type;

endpackage

// ----- src/timer_expiry_priority_queue.sv -----
// Top level of the timer expiry queue: controller plus datapath.
// Throughput: one item at a time; busy drops in the cycle the result strobe is high.
// Stop scans the store once, poll twice (search, then compaction), through one read port.
// Synchronous active-high reset empties the queue and zeroes the id counter.
// The receiver cannot stall: rsp_valid marks a result for one cycle.
module timer_expiry_priority_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [47:0] req_now_time,
   input  logic [47:0] req_interval,
   input  logic [31:0] req_target_id,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_tmr_id,
   output logic [4:0]  rsp_pending
);
   import tepq_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   tepq_ctrl u_ctrl (
      .clock, .reset, .start, .req_opcode, .busy, .sts, .cmd);

   tepq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
      .clock, .reset, .cmd, .req_opcode, .req_now_time, .req_interval,
      .req_target_id, .sts, .rsp_valid, .rsp_status, .rsp_tmr_id, .rsp_pending);
endmodule

// ----- src/tepq_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
module tepq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- src/tepq_datapath.sv -----
// Datapath: timer storage, scan pointers, best-entry search and result regs.
module tepq_datapath #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tepq_pkg::dp_cmd_type  cmd,
   input  logic [1:0]            req_opcode,
   input  logic [47:0]           req_now_time,
   input  logic [47:0]           req_interval,
   input  logic [31:0]           req_target_id,
   output tepq_pkg::dp_sts_type  sts,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [31:0]           rsp_tmr_id,
   output logic [4:0]            rsp_pending
);
   import tepq_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [1:0]        op_ff;
   logic [TIME_W-1:0] now_ff, ivl_ff;
   logic [ID_W-1:0]   tgt_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [ID_W-1:0]   next_id_ff;
   logic [CW-1:0]     rd_ptr_ff, wr_ptr_ff, best_ff;
   logic [ID_W-1:0]   best_id_ff;
   logic [TIME_W-1:0] best_exp_ff;
   logic              have_ff, found_ff, rd_vld_ff;
   logic [ID_W-1:0]   rid;
   logic [TIME_W-1:0] rexp;
   logic [TIME_W:0]   exp_sum;
   logic [TIME_W-1:0] exp_sat;
   logic              drop, better, remove;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [ID_W-1:0]   wr_id;
   logic [TIME_W-1:0] wr_exp;
   logic [1:0]        st;
   logic [ID_W-1:0]   res_id;

   tepq_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_id_ram (
      .clock, .wr_en, .wr_addr, .wr_data(wr_id),
      .rd_addr(rd_ptr_ff[AW-1:0]), .rd_data(rid));
   tepq_ram #(.WIDTH(TIME_W), .DEPTH(QUEUE_DEPTH)) u_exp_ram (
      .clock, .wr_en, .wr_addr, .wr_data(wr_exp),
      .rd_addr(rd_ptr_ff[AW-1:0]), .rd_data(rexp));

   // saturating expiry
   assign exp_sum = {1'b0, now_ff} + {1'b0, ivl_ff};
   assign exp_sat = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];

   // poll drops the best slot only when it has expired; stop drops on id match
   assign remove = have_ff && (best_exp_ff <= now_ff);
   assign drop   = (op_ff == OP_STOP) ? (rid == tgt_ff)
                 : (remove && ((rd_ptr_ff - CW'(1)) == best_ff));
   assign better = !have_ff || (rexp < best_exp_ff) ||
                   ((rexp == best_exp_ff) && (rid < best_id_ff));

   assign sts.full    = (count_ff >= CW'(QUEUE_DEPTH));
   assign sts.empty   = (count_ff == '0);
   assign sts.rd_last = (rd_ptr_ff + CW'(1) >= count_ff);

   // memory write port: append or compaction copy
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_id   = next_id_ff;
      wr_exp  = exp_sat;
      if (cmd.wr_start) begin
         wr_en = 1'b1;
      end else if (cmd.shift && rd_vld_ff && !drop) begin
         wr_en   = 1'b1;
         wr_addr = wr_ptr_ff[AW-1:0];
         wr_id   = rid;
         wr_exp  = rexp;
      end
   end

   // result selection
   always_comb begin
      st       = ST_OK;
      res_id   = '0;
      count_in = count_ff;
      unique case (op_ff)
         OP_START: begin
            if (sts.full) begin
               st = ST_FULL;
            end else begin
               res_id   = next_id_ff;
               count_in = count_ff + CW'(1);
            end
         end
         OP_STOP: begin
            if (found_ff) begin
               res_id   = tgt_ff;
               count_in = wr_ptr_ff;
            end else begin
               st = ST_NOT_FOUND;
            end
         end
         OP_POLL: begin
            if (remove) begin
               res_id   = best_id_ff;
               count_in = wr_ptr_ff;
            end else begin
               st = ST_NO_EXPIRY;
            end
         end
         default: ;
      endcase
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         now_ff <= req_now_time;
         ivl_ff <= req_interval;
         tgt_ff <= req_target_id;
      end
   end

   // scan pointers and search state
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         have_ff   <= 1'b0;
         found_ff  <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd;
         if (cmd.scan_clr) begin
            rd_ptr_ff <= '0;
            wr_ptr_ff <= '0;
            found_ff  <= 1'b0;
            rd_vld_ff <= 1'b0;
         end else if (cmd.rd) begin
            rd_ptr_ff <= rd_ptr_ff + CW'(1);
         end
         if (cmd.load) begin
            have_ff <= 1'b0;
         end
         if (cmd.eval && rd_vld_ff && better) begin
            have_ff     <= 1'b1;
            best_ff     <= rd_ptr_ff - CW'(1);
            best_id_ff  <= rid;
            best_exp_ff <= rexp;
         end
         if (cmd.shift && rd_vld_ff) begin
            if (!drop) begin
               wr_ptr_ff <= wr_ptr_ff + CW'(1);
            end else begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   // counts and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         next_id_ff <= '0;
         rsp_valid  <= 1'b0;
      end else begin
         rsp_valid <= cmd.finish;
         if (cmd.finish) begin
            count_ff <= count_in;
            if (op_ff == OP_START && !sts.full) begin
               next_id_ff <= next_id_ff + ID_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status  <= st;
         rsp_tmr_id  <= res_id;
         rsp_pending <= 5'(count_in);
      end
   end
endmodule

// ----- src/tepq_ctrl.sv -----
// Controller: sequences start, stop and poll passes over the timer store.
module tepq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_opcode,
   output logic                 busy,
   input  tepq_pkg::dp_sts_type sts,
   output tepq_pkg::dp_cmd_type cmd
);
   import tepq_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SEARCH = 6'b000010,
      S_SDRAIN = 6'b000100,
      S_SHIFT  = 6'b001000,
      S_DRAIN  = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      is_start_ff;

   assign busy = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load     = 1'b1;
               cmd.scan_clr = 1'b1;
               unique case (req_opcode)
                  OP_STOP:  state_in = S_SHIFT;
                  OP_POLL:  state_in = S_SEARCH;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_SEARCH: begin
            cmd.eval = 1'b1;
            if (sts.empty) begin
               state_in = S_DONE;
            end else begin
               cmd.rd = 1'b1;
               if (sts.rd_last) state_in = S_SDRAIN;
            end
         end
         S_SDRAIN: begin
            cmd.eval     = 1'b1;
            cmd.scan_clr = 1'b1;
            state_in     = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.empty) begin
               state_in = S_DONE;
            end else begin
               cmd.rd = 1'b1;
               if (sts.rd_last) state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            cmd.shift = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            cmd.finish   = 1'b1;
            cmd.wr_start = is_start_ff && !sts.full;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         is_start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE && start) begin
            is_start_ff <= (req_opcode == OP_START);
         end
      end
   end
endmodule

// ----- sim/timer_expiry_priority_queue_tb.sv -----
// Testbench for the timer expiry queue: random and directed timer operations checked
// against a behavioral queue model.
`timescale 1ns / 100ps

module timer_expiry_priority_queue_tb;
   import tepq_pkg::*;

   localparam int DEPTH = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      opcode_type  op;
      logic [47:0] now_time;
      logic [47:0] interval;
      logic [31:0] target_id;
      bit          drain;   // wait for every result before this item
   } timer_op_type;

   typedef struct {
      status_type  status;
      logic [31:0] tmr_id;
      logic [4:0]  pending;
   } timer_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = '0;
   logic [47:0] req_now_time = '0;
   logic [47:0] req_interval = '0;
   logic [31:0] req_target_id = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_tmr_id;
   logic [4:0]  rsp_pending;

   timer_op_type   pending_ops[$];
   timer_rsp_type  expected_rsps[$];

   // shadow of the queue contents
   logic [31:0] shadow_id[$];
   logic [47:0] shadow_expiry[$];
   logic [31:0] shadow_next_id;

   int error_count = 0;
   int cycle_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int fired_count = 0;
   int full_count = 0;
   int gap_left = 0;
   bit all_queued = 0;

   timer_expiry_priority_queue #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_now_time(req_now_time),
      .req_interval(req_interval), .req_target_id(req_target_id),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_tmr_id(rsp_tmr_id), .rsp_pending(rsp_pending)
   );

   always #5 clock = ~clock;

   // Compute the queue's answer to one operation and update the shadow.
   function automatic timer_rsp_type apply_timer_op(timer_op_type t);
      timer_rsp_type r;
      logic [48:0] sum;
      int best;
      bit found;
      int k;
      r.status = ST_OK;
      r.tmr_id = '0;
      case (t.op)
         OP_START: begin
            if (shadow_id.size() >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               sum = {1'b0, t.now_time} + {1'b0, t.interval};
               shadow_id.insert(shadow_id.size(), shadow_next_id);
               shadow_expiry.insert(shadow_expiry.size(), sum[48] ? TIME_MAX : sum[47:0]);
               r.tmr_id = shadow_next_id;
               shadow_next_id = shadow_next_id + 32'd1;
            end
         end
         OP_STOP: begin
            found = 0;
            k = 0;
            while (k < shadow_id.size()) begin
               if (shadow_id[k] == t.target_id) begin
                  found = 1;
                  shadow_id.delete(k);
                  shadow_expiry.delete(k);
               end else begin
                  k++;
               end
            end
            if (found) r.tmr_id = t.target_id;
            else r.status = ST_NOT_FOUND;
         end
         OP_POLL: begin
            best = -1;
            foreach (shadow_id[i]) begin
               if (best < 0 || shadow_expiry[i] < shadow_expiry[best] ||
                   (shadow_expiry[i] == shadow_expiry[best] &&
                    shadow_id[i] < shadow_id[best]))
                  best = i;
            end
            if (best >= 0 && shadow_expiry[best] <= t.now_time) begin
               r.tmr_id = shadow_id[best];
               shadow_id.delete(best);
               shadow_expiry.delete(best);
            end else begin
               r.status = ST_NO_EXPIRY;
            end
         end
         default: ;
      endcase
      r.pending = 5'(shadow_id.size());
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      $display("MISMATCH item %0d %s: got %0h expected %0h", checked_count, what, got, want);
      error_count++;
   endtask

   function automatic timer_op_type make_op(opcode_type op, logic [47:0] now_t,
                                            logic [47:0] ivl, logic [31:0] tgt);
      timer_op_type t;
      t.op = op;
      t.now_time = now_t;
      t.interval = ivl;
      t.target_id = tgt;
      t.drain = 0;
      return t;
   endfunction

   // Append one item to the pending stimulus.
   task automatic queue_op(timer_op_type t);
      pending_ops.insert(pending_ops.size(), t);
   endtask

   // Drive items: hold each until accepted, then draw a gap.
   always @(posedge clock) begin
      timer_op_type t;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         t = pending_ops.pop_front();
         expected_rsps.insert(expected_rsps.size(), apply_timer_op(t));
         sent_count <= sent_count + 1;
         start <= 1'b0;
         gap_left <= $urandom_range(0, 3);
      end else if (!start && gap_left > 0) begin
         gap_left <= gap_left - 1;
      end else if (!start && pending_ops.size() > 0 &&
                   !(pending_ops[0].drain && expected_rsps.size() > 0)) begin
         t = pending_ops[0];
         req_opcode <= t.op;
         req_now_time <= t.now_time;
         req_interval <= t.interval;
         req_target_id <= t.target_id;
         start <= 1'b1;
      end
   end

   // Check each result strobe against the oldest expectation.
   always @(posedge clock) begin
      timer_rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result status", 48'(rsp_status), '0);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_status != e.status) report_mismatch("status", 48'(rsp_status), 48'(e.status));
            if (rsp_tmr_id != e.tmr_id) report_mismatch("tmr_id", 48'(rsp_tmr_id), 48'(e.tmr_id));
            if (rsp_pending != e.pending)
               report_mismatch("pending", 48'(rsp_pending), 48'(e.pending));
            if (e.status == ST_OK && rsp_status == ST_OK && e.tmr_id != 0) fired_count++;
            if (e.status == ST_FULL) full_count++;
            checked_count++;
         end
      end
   end

   // Directed items, then random bursts of mostly well-formed timer traffic.
   initial begin
      timer_op_type t;
      int n;
      int r;
      logic [47:0] tnow;
      logic [31:0] tid;
      shadow_next_id = '0;
      // extremes and special cases
      queue_op(make_op(OP_POLL, '0, '0, '0));            // poll on empty
      queue_op(make_op(OP_STOP, '0, '0, 32'hFFFF_FFFF)); // unknown id
      queue_op(make_op(OP_NONE, TIME_MAX, TIME_MAX, 32'hFFFF_FFFF));
      queue_op(make_op(OP_START, TIME_MAX, TIME_MAX, '0)); // saturates
      queue_op(make_op(OP_START, 48'd5, 48'd0, '0));
      queue_op(make_op(OP_START, 48'd0, 48'd5, '0));    // same expiry, higher id
      queue_op(make_op(OP_POLL, 48'd4, '0, '0));        // nothing expired
      queue_op(make_op(OP_POLL, 48'd5, '0, '0));        // tie, lower id
      queue_op(make_op(OP_STOP, '0, '0, 32'd2));
      queue_op(make_op(OP_POLL, TIME_MAX, '0, '0));     // saturated timer
      // fill past full
      for (int i = 0; i < DEPTH + 2; i++)
         queue_op(make_op(OP_START, 48'd100, 48'($urandom_range(0, 50)), '0));
      t = make_op(OP_POLL, 48'd1000, '0, '0);
      t.drain = 1;
      queue_op(t);
      n = pending_ops.size();
      tnow = 48'd1000;
      while (n < 760) begin
         r = $urandom_range(0, 99);
         tnow = tnow + 48'($urandom_range(0, 20));
         if (r < 45) begin
            t = make_op(OP_START, tnow, 48'($urandom_range(0, 60)), '0);
            if ($urandom_range(0, 19) == 0)
               t.interval = 48'({$urandom, $urandom});
            if ($urandom_range(0, 29) == 0)
               t.now_time = 48'({$urandom, $urandom});
         end else if (r < 62) begin
            // ids drawn from zero up to the count of items queued so far
            tid = 32'($urandom_range(0, n));
            if ($urandom_range(0, 9) == 0) tid = $urandom;
            t = make_op(OP_STOP, 48'({$urandom, $urandom}),
                        48'({$urandom, $urandom}), tid);
         end else if (r < 97) begin
            t = make_op(OP_POLL, tnow, 48'({$urandom, $urandom}), $urandom);
            if ($urandom_range(0, 29) == 0) t.now_time = 48'({$urandom, $urandom});
         end else begin
            t = make_op(OP_NONE, 48'({$urandom, $urandom}),
                        48'({$urandom, $urandom}), $urandom);
         end
         if ($urandom_range(0, 99) == 0) t.drain = 1;
         queue_op(t);
         n++;
      end
      all_queued = 1;
   end

   // Release reset, wait for the stimulus to drain, then report.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (all_queued);
      while ((pending_ops.size() > 0 || expected_rsps.size() > 0 || start)
             && cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      repeat (50) @(posedge clock);
      $display("Ran %0d timer operations, %0d results checked, %0d ok with id, %0d full",
               sent_count, checked_count, fired_count, full_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
